>>> rtl/rudt_pkg.sv
package rudt_pkg;

    localparam int RUDT_DEPTH = 16;
    localparam int ID_W       = 64;
    localparam int USE_W      = 2;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int STAT_W     = 2;

    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(16);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MISS,
        ST_DONE
    } rudt_state_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK,
        STAT_BAD_ID,
        STAT_BAD_USE,
        STAT_FULL
    } rudt_status_t;

    // memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_id_en;
        logic wr_use_en;
    } rudt_mem_ctl_t;

endpackage

>>> rtl/rudt_store.sv
module rudt_store
    import rudt_pkg::*;
#(
    parameter int DEPTH  = RUDT_DEPTH,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  rudt_mem_ctl_t     ctl,
    input  logic [ADDR_W-1:0] rd_addr,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ID_W-1:0]   wr_id,
    input  logic [USE_W-1:0]  wr_use,
    output logic [ID_W-1:0]   rd_id,
    output logic [USE_W-1:0]  rd_use
);

    logic [ID_W-1:0]  id_mem  [DEPTH];
    logic [USE_W-1:0] use_mem [DEPTH];

    logic [ID_W-1:0]  rd_id_reg;
    logic [USE_W-1:0] rd_use_reg;

    always_ff @(posedge aclk) begin
        if (ctl.wr_id_en) begin
            id_mem[wr_addr] <= wr_id;
        end
        if (ctl.wr_use_en) begin
            use_mem[wr_addr] <= wr_use;
        end
    end

    // registered read port, data holds between reads
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_id_reg  <= id_mem[rd_addr];
            rd_use_reg <= use_mem[rd_addr];
        end
    end

    assign rd_id  = rd_id_reg;
    assign rd_use = rd_use_reg;

endmodule

>>> rtl/resource_usage_dedup_table.sv
// A miss scans every entry held in the identity memory, one entry per cycle, before it is
// appended or refused as full; a hit in slot j ends the scan there. A rejected request skips
// the scan. One request at a time: the next is taken the cycle after its result loads the
// output register, which waits while the result channel stalls.
// Reset (aresetn, synchronous, active low): table empty, table_limit = 16, no result
// pending. Table memories are not cleared; only slots below the fill count are read.
module resource_usage_dedup_table
    import rudt_pkg::*;
#(
    parameter int TABLE_DEPTH = RUDT_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,

    // configuration: table_limit
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,

    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_batch_start,
    input  logic [ID_W-1:0]   s_res_identity,
    input  logic [USE_W-1:0]  s_usage_bits,

    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [IDX_W-1:0]  m_entry_index,
    output logic [USE_W-1:0]  m_entry_usage,
    output logic              m_is_new,
    output logic [CNT_W-1:0]  m_entry_count
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // usable slots: table_limit is capped by the depth and by its own range
    localparam int CAP_I  = (TABLE_DEPTH < (2**CNT_W - 1)) ? TABLE_DEPTH : (2**CNT_W - 1);
    localparam logic [CNT_W-1:0] LIM_CAP = CNT_W'(CAP_I);

    rudt_state_t       state_reg, state_next;

    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;       // filled_count
    logic [CNT_W-1:0]  scan_reg, scan_next;     // slot whose data sits on the read port
    logic [ID_W-1:0]   id_reg, id_next;
    logic [USE_W-1:0]  use_reg, use_next;

    // result of the current transaction, waiting for the output register
    rudt_status_t      res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_index_reg, res_index_next;
    logic [USE_W-1:0]  res_usage_reg, res_usage_next;
    logic              res_new_reg, res_new_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg;
    logic [IDX_W-1:0]  m_index_reg;
    logic [USE_W-1:0]  m_usage_reg;
    logic              m_new_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic              out_load;

    // table memory port
    rudt_mem_ctl_t     mem_ctl;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [USE_W-1:0]  wr_use;
    logic [ID_W-1:0]   rd_id;
    logic [USE_W-1:0]  rd_use;

    logic [CNT_W-1:0]  eff_limit;
    logic [CNT_W-1:0]  cnt_start;
    logic [CNT_W-1:0]  scan_inc;
    logic              in_fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;

    assign eff_limit = (limit_reg > LIM_CAP) ? LIM_CAP : limit_reg;
    // batch start empties the table even when the request is rejected
    assign cnt_start = s_batch_start ? '0 : cnt_reg;
    assign scan_inc  = scan_reg + CNT_W'(1);

    rudt_store #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_id   (id_reg),
        .wr_use  (wr_use),
        .rd_id   (rd_id),
        .rd_use  (rd_use)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= LIMIT_RESET;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        scan_reg        <= scan_next;
        id_reg          <= id_next;
        use_reg         <= use_next;
        res_status_reg  <= res_status_next;
        res_index_reg   <= res_index_next;
        res_usage_reg   <= res_usage_next;
        res_new_reg     <= res_new_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_index_reg  <= res_index_reg;
            m_usage_reg  <= res_usage_reg;
            m_new_reg    <= res_new_reg;
            m_count_reg  <= cnt_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        scan_next       = scan_reg;
        id_next         = id_reg;
        use_next        = use_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_usage_next  = res_usage_reg;
        res_new_next    = res_new_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_load        = 1'b0;
        mem_ctl         = '0;
        rd_addr         = ADDR_W'(scan_inc);
        wr_addr         = ADDR_W'(scan_reg);
        wr_use          = rd_use | use_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    id_next         = s_res_identity;
                    use_next        = s_usage_bits;
                    cnt_next        = cnt_start;
                    scan_next       = '0;
                    res_status_next = STAT_OK;
                    res_index_next  = '0;
                    res_usage_next  = '0;
                    res_new_next    = 1'b0;
                    priority if (s_res_identity == '0) begin
                        res_status_next = STAT_BAD_ID;
                        state_next      = ST_DONE;
                    end else if (s_usage_bits == '0) begin
                        res_status_next = STAT_BAD_USE;
                        state_next      = ST_DONE;
                    end else if (cnt_start == '0) begin
                        state_next = ST_MISS;
                    end else begin
                        // fetch slot 0
                        mem_ctl.rd_en = 1'b1;
                        rd_addr       = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (rd_id == id_reg) begin
                    // hit: OR the new usage into the slot
                    mem_ctl.wr_use_en = 1'b1;
                    wr_addr           = ADDR_W'(scan_reg);
                    wr_use            = rd_use | use_reg;
                    res_index_next    = IDX_W'(scan_reg);
                    res_usage_next    = rd_use | use_reg;
                    state_next        = ST_DONE;
                end else if (scan_inc == cnt_reg) begin
                    state_next = ST_MISS;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    rd_addr       = ADDR_W'(scan_inc);
                    scan_next     = scan_inc;
                end
            end

            ST_MISS: begin
                if (cnt_reg >= eff_limit) begin
                    res_status_next = STAT_FULL;
                end else begin
                    // append at the next free slot
                    mem_ctl.wr_id_en  = 1'b1;
                    mem_ctl.wr_use_en = 1'b1;
                    wr_addr           = ADDR_W'(cnt_reg);
                    wr_use            = use_reg;
                    cnt_next          = cnt_reg + CNT_W'(1);
                    res_index_next    = IDX_W'(cnt_reg);
                    res_usage_next    = use_reg;
                    res_new_next      = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_index = m_index_reg;
    assign m_entry_usage = m_usage_reg;
    assign m_is_new      = m_new_reg;
    assign m_entry_count = m_count_reg;

endmodule

>>> sim/tb_resource_usage_dedup_table.sv
module tb_resource_usage_dedup_table;
    timeunit 1ns;
    timeprecision 1ps;

    import rudt_pkg::*;

    localparam int ITEM_TARGET    = 1250;
    // receiver hold-off while the sender keeps pushing; far longer than a full table scan
    localparam int HOLD_CYCLES    = 300;
    // cycles with no transaction on any channel before the run is declared hung
    localparam int WATCHDOG_LIMIT = 3000;
    // settle time after the last result, longer than the worst-case scan
    localparam int SETTLE_CYCLES  = 40;

    // usage encodings on s_usage_bits
    localparam logic [USE_W-1:0] USE_NONE  = 2'd0;
    localparam logic [USE_W-1:0] USE_READ  = 2'd1;
    localparam logic [USE_W-1:0] USE_WRITE = 2'd2;
    localparam logic [USE_W-1:0] USE_RW    = 2'd3;

    // idle behavior of a channel for one phase
    typedef enum int {
        IDLE_NONE,
        IDLE_SHORT,
        IDLE_MIXED
    } idle_mode_t;

    typedef struct packed {
        rudt_status_t     status;
        logic [IDX_W-1:0] index;
        logic [USE_W-1:0] usage;
        logic             fresh;
        logic [CNT_W-1:0] count;
    } dedup_result_t;

    // Shadow of the dedup table plus the queue of results it predicts.
    class dedup_scoreboard;
        logic [ID_W-1:0]  held_id  [RUDT_DEPTH];
        logic [USE_W-1:0] held_use [RUDT_DEPTH];
        int unsigned      held_count;
        int unsigned      limit;
        dedup_result_t    expected_q[$];
        int               errors;
        int               checked;
        int               n_new;
        int               n_merge;
        int               n_full;
        int               n_bad_id;
        int               n_bad_use;

        function new();
            held_count = 0;
            limit      = LIMIT_RESET;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Apply one accepted request to the shadow table and queue its result.
        function void note_request(logic batch, logic [ID_W-1:0] id,
                                   logic [USE_W-1:0] usage);
            dedup_result_t r;
            int unsigned   eff_limit;
            int            hit;
            r.status = STAT_OK;
            r.index  = '0;
            r.usage  = '0;
            r.fresh  = 1'b0;
            hit      = -1;
            if (batch)
                held_count = 0;
            eff_limit = (limit > RUDT_DEPTH) ? RUDT_DEPTH : limit;
            // zero identity outranks a bad usage; both skip the search
            if (id == '0) begin
                r.status = STAT_BAD_ID;
                n_bad_id++;
            end else if (usage == USE_NONE) begin
                r.status = STAT_BAD_USE;
                n_bad_use++;
            end else begin
                for (int i = 0; i < held_count; i++)
                    if (hit < 0 && held_id[i] == id)
                        hit = i;
                if (hit >= 0) begin
                    // held identities merge even when the limit has dropped below the count
                    held_use[hit] = held_use[hit] | usage;
                    r.index       = IDX_W'(hit);
                    r.usage       = held_use[hit];
                    n_merge++;
                end else if (held_count >= eff_limit) begin
                    r.status = STAT_FULL;
                    n_full++;
                end else begin
                    held_id[held_count]  = id;
                    held_use[held_count] = usage;
                    r.index              = IDX_W'(held_count);
                    r.usage              = usage;
                    r.fresh              = 1'b1;
                    held_count++;
                    n_new++;
                end
            end
            r.count = CNT_W'(held_count);
            expected_q.push_back(r);
        endfunction

        function void match_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(dedup_result_t got);
            dedup_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request pending, status %0d index %0d count %0d",
                         $time, got.status, got.index, got.count);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            match_field("status",      want.status, got.status);
            match_field("entry_index", want.index,  got.index);
            match_field("entry_usage", want.usage,  got.usage);
            match_field("is_new",      want.fresh,  got.fresh);
            match_field("entry_count", want.count,  got.count);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;
    logic              s_valid;
    logic              s_ready;
    logic              s_batch_start;
    logic [ID_W-1:0]   s_res_identity;
    logic [USE_W-1:0]  s_usage_bits;
    logic              m_valid;
    logic              m_ready;
    logic [STAT_W-1:0] m_status;
    logic [IDX_W-1:0]  m_entry_index;
    logic [USE_W-1:0]  m_entry_usage;
    logic              m_is_new;
    logic [CNT_W-1:0]  m_entry_count;

    dedup_scoreboard sb = new();

    idle_mode_t  tx_mode    = IDLE_MIXED;
    idle_mode_t  rx_mode    = IDLE_MIXED;
    bit          hold_req   = 1'b0;   // main asks the receiver for one long hold-off
    int          items_sent = 0;
    bit [31:0]   limits_seen = '0;

    resource_usage_dedup_table i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_batch_start  (s_batch_start),
        .s_res_identity (s_res_identity),
        .s_usage_bits   (s_usage_bits),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_entry_index  (m_entry_index),
        .m_entry_usage  (m_entry_usage),
        .m_is_new       (m_is_new),
        .m_entry_count  (m_entry_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle length for one decision: mostly zero or short, rarely long in mixed mode.
    function automatic int idle_len(idle_mode_t mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_SHORT: return ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
            default:    return ($urandom_range(9) == 0) ? $urandom_range(10, 50)
                                                        : $urandom_range(0, 3);
        endcase
    endfunction

    // Identity mix: small keys, all-ones, and full-width random keys.
    function automatic logic [ID_W-1:0] random_identity();
        case ($urandom_range(9))
            0:       return ID_W'($urandom_range(1, 20));
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one request; inputs move only at the falling edge, acceptance is
    // seen at the rising edge. With no gap, valid simply stays high.
    task automatic send_request(input logic batch, input logic [ID_W-1:0] id,
                                input logic [USE_W-1:0] usage);
        int gap;
        gap = idle_len(tx_mode);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_batch_start  = batch;
        s_res_identity = id;
        s_usage_bits   = usage;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(batch, id, usage);
        items_sent++;
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // table_limit is only written with the block idle: every request yields a
    // result, so an empty expectation queue means the scan engine is at rest.
    task automatic write_limit(input logic [CNT_W-1:0] value);
        drain_results();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.limit           = value;
        limits_seen[value] = 1'b1;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // One request list: a small identity pool so that merges are frequent,
    // some near-duplicate keys (one bit apart) to stress the 64-bit compare,
    // plus a sprinkle of bad identities, bad usages and stray batch starts.
    task automatic run_batch(input bit clear_first);
        logic [ID_W-1:0]  pool [20];
        int               pool_n;
        int               len;
        int               pick;
        logic             batch;
        logic [ID_W-1:0]  id;
        logic [USE_W-1:0] usage;
        pool_n = $urandom_range(1, 20);
        for (int k = 0; k < pool_n; k++) begin
            if (k > 0 && $urandom_range(4) == 0)
                pool[k] = pool[0] ^ (ID_W'(1) << $urandom_range(ID_W - 1));
            else
                pool[k] = random_identity();
        end
        len = $urandom_range(4, 40);
        for (int k = 0; k < len; k++) begin
            batch = (k == 0) ? clear_first : ($urandom_range(49) == 0);
            pick  = $urandom_range(99);
            id    = pool[$urandom_range(pool_n - 1)];
            usage = USE_W'($urandom_range(USE_READ, USE_RW));
            if (pick < 4) begin
                id = '0;
            end else if (pick < 8) begin
                usage = USE_NONE;
            end else if (pick < 10) begin
                id    = '0;
                usage = USE_NONE;
            end else if (pick < 15) begin
                id = random_identity();
            end
            send_request(batch, id, usage);
        end
    endtask

    // Result-side ready. The hold-off is counted here, independent of the sender,
    // so the sender keeps offering while the output register sits full.
    initial begin : receiver
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                stall = idle_len(rx_mode);
                if (stall == 0) begin
                    m_ready = 1'b1;
                end else begin
                    m_ready = 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
        end
    end

    // Result checking and the hang watchdog, both on the rising edge.
    initial begin : monitor
        dedup_result_t got;
        int            idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_valid && m_ready) begin
                    got.status = rudt_status_t'(m_status);
                    got.index  = m_entry_index;
                    got.usage  = m_entry_usage;
                    got.fresh  = m_is_new;
                    got.count  = m_entry_count;
                    sb.check_result(got);
                end
                if ((m_valid && m_ready) || (s_valid && s_ready) || (cfg_valid && cfg_ready))
                    idle_cycles = 0;
                else
                    idle_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles, giving up", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [CNT_W-1:0] lim;
        int               n_batches;
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_batch_start  = 1'b0;
        s_res_identity = '0;
        s_usage_bits   = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // ---- directed: runs first on the reset limit of 16 ----
        send_request(1'b1, ID_W'(1), USE_READ);          // fresh table, slot 0
        send_request(1'b0, '0, USE_NONE);                // zero identity reported before bad usage
        send_request(1'b0, ID_W'(5), USE_NONE);          // bad usage
        send_request(1'b0, ID_W'(1), USE_WRITE);         // merge read + write
        send_request(1'b0, '1, USE_RW);                  // all-ones key
        send_request(1'b0, {1'b1, 63'd0}, USE_WRITE);    // top bit only
        send_request(1'b1, '0, USE_READ);                // error right after a clear: count 0
        send_request(1'b1, '1, USE_READ);                // clear again, slot 0
        for (int k = 2; k <= RUDT_DEPTH; k++)
            send_request(1'b0, ID_W'(k), USE_WRITE);     // fill to depth
        send_request(1'b0, 64'h0123_4567_89ab_cdef, USE_READ);  // full at depth
        send_request(1'b0, ID_W'(RUDT_DEPTH), USE_READ); // merge into last slot
        write_limit(CNT_W'(2));                          // limit lowered mid-batch
        send_request(1'b0, ID_W'(5), USE_READ);          // held key still merges
        send_request(1'b0, ID_W'(99), USE_RW);           // new key refused
        write_limit(CNT_W'(0));
        send_request(1'b1, ID_W'(7), USE_RW);            // zero limit: full even when empty
        write_limit(CNT_W'(31));                         // above depth, acts as 16
        tx_mode = IDLE_NONE;
        run_batch(1'b1);

        // ---- back-pressure: receiver stalls, sender keeps offering ----
        write_limit(CNT_W'(16));
        hold_req = 1'b1;
        run_batch(1'b1);
        // sender pauses until everything is back
        drain_results();

        // ---- random phases: new limit, new idle pattern, a few request lists ----
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(9))
                0:       lim = '0;
                1:       lim = CNT_W'(16);
                2:       lim = CNT_W'($urandom_range(17, 31));
                default: lim = CNT_W'($urandom_range(1, 15));
            endcase
            write_limit(lim);
            tx_mode   = idle_mode_t'($urandom_range(2));
            rx_mode   = idle_mode_t'($urandom_range(2));
            n_batches = $urandom_range(1, 4);
            // first list sometimes keeps the old table, so a new limit lands mid-batch
            for (int b = 0; b < n_batches; b++)
                run_batch((b == 0) ? ($urandom_range(9) < 7) : ($urandom_range(9) < 8));
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d requests: %0d appended, %0d merged, %0d refused as full,",
                 items_sent, sb.n_new, sb.n_merge, sb.n_full);
        $display("%0d bad identity, %0d bad usage; %0d results compared over %0d limits.",
                 sb.n_bad_id, sb.n_bad_use, sb.checked, $countones(limits_seen));
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
